// ===== rtl/rrc_pkg.sv =====
// Shared constants for the reflection resolution calculator.
// Result status codes and configuration register indexes; no dependencies.
`default_nettype none

package rrc_pkg;

	// Result status codes.
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_ZERO   = 2'd1;
	localparam logic [1:0] ST_NONPOS = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] REG_HH = 3'd0;
	localparam logic [2:0] REG_KK = 3'd1;
	localparam logic [2:0] REG_LL = 3'd2;
	localparam logic [2:0] REG_HK = 3'd3;
	localparam logic [2:0] REG_HL = 3'd4;
	localparam logic [2:0] REG_KL = 3'd5;

	// Result bits produced by the root stages.
	localparam int ROOT_BITS = 32;

endpackage

`default_nettype wire

// ===== rtl/rrc_root_stage.sv =====
// One digit stage of the two square-root recurrences (sin(theta)/lambda and d).
// Uses rrc_pkg for the result width; instantiated by reflection_resolution_calc.
`default_nettype none

module rrc_root_stage
	import rrc_pkg::*;
#(
	parameter int BIT = 31,
	parameter int QPW = 53,
	parameter int LSW = 65,
	parameter int LDW = 69,
	parameter int RQW = 85
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 up_valid,
	output logic                      up_ready,
	output logic                      dn_valid,
	input  wire logic                 dn_ready,
	input  wire logic [QPW-1:0]       q_in,
	input  wire logic [1:0]           st_in,
	input  wire logic [LSW-1:0]       rs_in,
	input  wire logic [LDW-1:0]       rd_in,
	input  wire logic [RQW-1:0]       rq_in,
	input  wire logic [ROOT_BITS-1:0] ts_in,
	input  wire logic [ROOT_BITS-1:0] td_in,
	output logic [QPW-1:0]            q_s,
	output logic [1:0]                st_s,
	output logic [LSW-1:0]            rs_s,
	output logic [LDW-1:0]            rd_s,
	output logic [RQW-1:0]            rq_s,
	output logic [ROOT_BITS-1:0]      ts_s,
	output logic [ROOT_BITS-1:0]      td_s
);

	localparam int CSW = ((LSW > ROOT_BITS + 36) ? LSW : ROOT_BITS + 36) + 1;
	localparam int DSW = RQW + ROOT_BITS + 2;

	logic [CSW-1:0] s_term;
	logic [DSW-1:0] d_term;
	logic           s_ok;
	logic           d_ok;
	logic           adv;

	// Growth of 4*t^2 when this bit is set: 4*(2^(b+1)*t + 2^(2b)).
	assign s_term = (CSW'(ts_in) << (BIT + 3)) + (CSW'(1) << (2 * BIT + 2));
	assign s_ok   = s_term <= CSW'(rs_in);

	// Growth of r^2*Q when this bit is set: 2^(b+1)*r*Q + 2^(2b)*Q.
	assign d_term = (DSW'(rq_in) << (BIT + 1)) + (DSW'(q_in) << (2 * BIT));
	assign d_ok   = d_term <= DSW'(rd_in);

	assign up_ready = !dn_valid || dn_ready;
	assign adv      = up_valid && up_ready;

	// Valid bit of this stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dn_valid <= 1'b0;
		end else if (up_ready) begin
			dn_valid <= up_valid;
		end
	end

	// Residuals shrink and the partial roots grow where the bit is kept.
	always_ff @(posedge clk) begin
		if (adv) begin
			q_s  <= q_in;
			st_s <= st_in;
			rs_s <= s_ok ? rs_in - s_term[LSW-1:0] : rs_in;
			ts_s <= s_ok ? ts_in | (ROOT_BITS'(1) << BIT) : ts_in;
			rd_s <= d_ok ? rd_in - d_term[LDW-1:0] : rd_in;
			rq_s <= d_ok ? rq_in + (RQW'(q_in) << BIT) : rq_in;
			td_s <= d_ok ? td_in | (ROOT_BITS'(1) << BIT) : td_in;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/reflection_resolution_calc.sv =====
// Top level of the reflection resolution calculator: quadratic form and roots.
// Depends on rrc_pkg and rrc_root_stage.
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------------------------------
//   input    | in_valid / in_ready  | index_h, index_k, index_l
//   output   | out_valid/out_ready  | sin_theta_over_lambda, resolution, status
//   config   | cfg_we               | cfg_index, cfg_wdata
//
// One item per cycle enters while the output is not stalled; each item passes
// three front stages for the index products, coefficient products and form
// sum, then the 32 root stages, one per result bit. Each stage stalls only when
// the one after it is full, so bubbles are squeezed out under backpressure.
// Reset clears all valid bits and sets every coefficient to zero.
`default_nettype none

module reflection_resolution_calc
	import rrc_pkg::*;
#(
	parameter int INDEX_BITS     = 9,
	parameter int COEF_FRAC_BITS = 36
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic signed [INDEX_BITS-1:0] index_h,
	input  wire logic signed [INDEX_BITS-1:0] index_k,
	input  wire logic signed [INDEX_BITS-1:0] index_l,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [31:0]                       sin_theta_over_lambda,
	output logic [31:0]                       resolution,
	output logic [1:0]                        status,
	input  wire logic                         cfg_we,
	input  wire logic [2:0]                   cfg_index,
	input  wire logic [31:0]                  cfg_wdata
);

	localparam int SQW = 2 * INDEX_BITS;
	localparam int PW  = SQW + 32;
	localparam int QW  = SQW + 36;
	localparam int QPW = QW - 1;
	localparam int SH  = 48 - COEF_FRAC_BITS;
	localparam int LSW = QPW + SH;
	localparam int LDW = 33 + COEF_FRAC_BITS;
	localparam int RQW = QPW + ROOT_BITS;
	localparam int NST = ROOT_BITS;

	logic [30:0] coef_hh_q, coef_kk_q, coef_ll_q;
	logic signed [31:0] coef_hk_q, coef_hl_q, coef_kl_q;

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_hh_q <= '0;
			coef_kk_q <= '0;
			coef_ll_q <= '0;
			coef_hk_q <= '0;
			coef_hl_q <= '0;
			coef_kl_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HH: coef_hh_q <= cfg_wdata[30:0];
				REG_KK: coef_kk_q <= cfg_wdata[30:0];
				REG_LL: coef_ll_q <= cfg_wdata[30:0];
				REG_HK: coef_hk_q <= cfg_wdata;
				REG_HL: coef_hl_q <= cfg_wdata;
				REG_KL: coef_kl_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;
	logic root_ready;
	logic signed [SQW-1:0] hh_s1, kk_s1, ll_s1, hk_s1, hl_s1, kl_s1;
	logic zero_s1, zero_s2;
	logic signed [PW-1:0] phh_s2, pkk_s2, pll_s2, phk_s2, phl_s2, pkl_s2;
	logic signed [QW-1:0] q_sum;
	logic [QPW-1:0] q_s3;
	logic [1:0] st_s3;

	assign rdy_s3   = !v_s3 || root_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// Valid bits of the front stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	// Stage 1: index products.
	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			hh_s1   <= SQW'(index_h) * SQW'(index_h);
			kk_s1   <= SQW'(index_k) * SQW'(index_k);
			ll_s1   <= SQW'(index_l) * SQW'(index_l);
			hk_s1   <= SQW'(index_h) * SQW'(index_k);
			hl_s1   <= SQW'(index_h) * SQW'(index_l);
			kl_s1   <= SQW'(index_k) * SQW'(index_l);
			zero_s1 <= (index_h == '0) && (index_k == '0) && (index_l == '0);
		end
	end

	// Stage 2: products with the metric coefficients.
	always_ff @(posedge clk) begin
		if (v_s1 && rdy_s2) begin
			phh_s2  <= PW'(hh_s1) * PW'($signed({1'b0, coef_hh_q}));
			pkk_s2  <= PW'(kk_s1) * PW'($signed({1'b0, coef_kk_q}));
			pll_s2  <= PW'(ll_s1) * PW'($signed({1'b0, coef_ll_q}));
			phk_s2  <= PW'(hk_s1) * PW'(coef_hk_q);
			phl_s2  <= PW'(hl_s1) * PW'(coef_hl_q);
			pkl_s2  <= PW'(kl_s1) * PW'(coef_kl_q);
			zero_s2 <= zero_s1;
		end
	end

	// Stage 3: sum of the form and classification.
	assign q_sum = QW'(phh_s2) + QW'(pkk_s2) + QW'(pll_s2)
		+ QW'(phk_s2) + QW'(phl_s2) + QW'(pkl_s2);

	always_ff @(posedge clk) begin
		if (v_s2 && rdy_s3) begin
			q_s3 <= q_sum[QPW-1:0];
			if (zero_s2) begin
				st_s3 <= ST_ZERO;
			end else if (q_sum[QW-1] || (q_sum == '0)) begin
				st_s3 <= ST_NONPOS;
			end else begin
				st_s3 <= ST_OK;
			end
		end
	end

	// Root stages, most significant bit first.
	logic                 v_w   [0:NST];
	logic                 rdy_w [0:NST];
	logic [QPW-1:0]       q_w   [0:NST];
	logic [1:0]           st_w  [0:NST];
	logic [LSW-1:0]       rs_w  [0:NST];
	logic [LDW-1:0]       rd_w  [0:NST];
	logic [RQW-1:0]       rq_w  [0:NST];
	logic [ROOT_BITS-1:0] ts_w  [0:NST];
	logic [ROOT_BITS-1:0] td_w  [0:NST];

	assign v_w[0]     = v_s3;
	assign root_ready = rdy_w[0];
	assign q_w[0]     = q_s3;
	assign st_w[0]    = st_s3;
	assign rs_w[0]    = LSW'(q_s3) << SH;
	assign rd_w[0]    = LDW'(1) << (32 + COEF_FRAC_BITS);
	assign rq_w[0]    = '0;
	assign ts_w[0]    = '0;
	assign td_w[0]    = '0;

	for (genvar j = 0; j < NST; j++) begin : g_root
		rrc_root_stage #(
			.BIT(NST - 1 - j),
			.QPW(QPW),
			.LSW(LSW),
			.LDW(LDW),
			.RQW(RQW)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (v_w[j]),
			.up_ready (rdy_w[j]),
			.dn_valid (v_w[j+1]),
			.dn_ready (rdy_w[j+1]),
			.q_in     (q_w[j]),
			.st_in    (st_w[j]),
			.rs_in    (rs_w[j]),
			.rd_in    (rd_w[j]),
			.rq_in    (rq_w[j]),
			.ts_in    (ts_w[j]),
			.td_in    (td_w[j]),
			.q_s      (q_w[j+1]),
			.st_s     (st_w[j+1]),
			.rs_s     (rs_w[j+1]),
			.rd_s     (rd_w[j+1]),
			.rq_s     (rq_w[j+1]),
			.ts_s     (ts_w[j+1]),
			.td_s     (td_w[j+1])
		);
	end

	// Output: the last root stage holds the result item.
	assign rdy_w[NST] = out_ready;
	assign out_valid  = v_w[NST];
	assign status     = st_w[NST];
	assign sin_theta_over_lambda = (st_w[NST] == ST_OK) ? ts_w[NST] : '0;
	assign resolution            = (st_w[NST] == ST_OK) ? td_w[NST] : '0;

endmodule

`default_nettype wire

// ===== rtl/rrc_checker.sv =====
// Port-level checks for reflection_resolution_calc, bound to the top level.
// Depends on rrc_pkg for the status codes.
`default_nettype none

module rrc_checker
	import rrc_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] sin_theta_over_lambda,
	input wire logic [31:0] resolution,
	input wire logic [1:0]  status
);

	// A stalled result item holds still.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)
		&& $stable(sin_theta_over_lambda) && $stable(resolution))
		else $error("result changed while stalled");

	// A result item leaves only when taken.
	a_leave: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("result dropped without handshake");

	// Flagged items carry zero values.
	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |->
		(sin_theta_over_lambda == '0) && (resolution == '0))
		else $error("flagged result has nonzero values");

	// The spare status code never appears.
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK) || (status == ST_ZERO) || (status == ST_NONPOS))
		else $error("undefined status code");

endmodule

bind reflection_resolution_calc rrc_checker u_rrc_checker (
	.clk                   (clk),
	.arst_n                (arst_n),
	.out_valid             (out_valid),
	.out_ready             (out_ready),
	.sin_theta_over_lambda (sin_theta_over_lambda),
	.resolution            (resolution),
	.status                (status)
);

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the reflection resolution calculator.
// Depends on rrc_pkg and the reflection_resolution_calc RTL; needs no files.
`timescale 1ns / 1ps

module testbench;
	import rrc_pkg::*;

	localparam int IDX_W = 9;
	localparam int DRAIN_CYCLES = 40;
	localparam int STALL_LIMIT = 5000;
	// Indexes outside the register map; writes there must be ignored.
	localparam logic [2:0] REG_SPARE_A = 3'd6;
	localparam logic [2:0] REG_SPARE_B = 3'd7;

	typedef struct packed {
		logic signed [IDX_W-1:0] h;
		logic signed [IDX_W-1:0] k;
		logic signed [IDX_W-1:0] l;
	} refl_t;

	typedef struct packed {
		logic [31:0] sthol;
		logic [31:0] dres;
		logic [1:0]  st;
	} res_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [IDX_W-1:0] index_h;
	logic signed [IDX_W-1:0] index_k;
	logic signed [IDX_W-1:0] index_l;
	logic out_valid;
	logic out_ready;
	logic [31:0] sin_theta_over_lambda;
	logic [31:0] resolution;
	logic [1:0] status;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [31:0] cfg_wdata;

	// Local copy of the metric coefficients.
	logic [30:0] m_hh, m_kk, m_ll;
	logic signed [31:0] m_hk, m_hl, m_kl;

	refl_t reflections[$];
	res_t expected_res[$];
	int errors;
	int idle_cycles;
	int in_gap;
	int out_stall;
	bit no_idle;

	reflection_resolution_calc dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.index_h(index_h), .index_k(index_k), .index_l(index_l),
		.out_valid(out_valid), .out_ready(out_ready),
		.sin_theta_over_lambda(sin_theta_over_lambda),
		.resolution(resolution), .status(status),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Quadratic form of the reciprocal metric, then both roots by bit search.
	function automatic res_t resolve_reflection(refl_t r);
		longint hv, kv, lv;
		logic signed [127:0] q;
		logic [127:0] qu, lim_s, lim_d, cs, cd;
		res_t o;
		hv = r.h;
		kv = r.k;
		lv = r.l;
		o = '0;
		q = 0;
		q = q + hv * hv * longint'(m_hh);
		q = q + kv * kv * longint'(m_kk);
		q = q + lv * lv * longint'(m_ll);
		q = q + hv * kv * longint'(m_hk);
		q = q + hv * lv * longint'(m_hl);
		q = q + kv * lv * longint'(m_kl);
		if (hv == 0 && kv == 0 && lv == 0) begin
			o.st = ST_ZERO;
		end else if (q <= 0) begin
			o.st = ST_NONPOS;
		end else begin
			qu = q;
			lim_s = qu << 12;
			lim_d = 128'd1 << 68;
			for (int b = 31; b >= 0; b--) begin
				cs = {96'd0, o.sthol} | (128'd1 << b);
				cd = {96'd0, o.dres} | (128'd1 << b);
				if (cs * cs * 4 <= lim_s)
					o.sthol = cs[31:0];
				if (cd * cd * qu <= lim_d)
					o.dres = cd[31:0];
			end
			o.st = ST_OK;
		end
		return o;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH %s: got 0x%08h expected 0x%08h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// Driver: present the next item once the slot is free and the gap has run out.
	always @(posedge clk or negedge arst_n) begin
		refl_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			index_h <= '0;
			index_k <= '0;
			index_l <= '0;
			in_gap <= 0;
		end else begin
			if (in_valid && in_ready)
				expected_res.push_back(resolve_reflection('{index_h, index_k, index_l}));
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 1'b0;
				end else if (reflections.size() > 0) begin
					nxt = reflections.pop_front();
					index_h <= nxt.h;
					index_k <= nxt.k;
					index_l <= nxt.l;
					in_valid <= 1'b1;
					in_gap <= pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each accepted result with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_stall <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_res.size() == 0) begin
					report_mismatch("unexpected item status", 32'(status), 32'd0);
				end else begin
					want = expected_res.pop_front();
					if (status !== want.st)
						report_mismatch("status", 32'(status), 32'(want.st));
					if (sin_theta_over_lambda !== want.sthol)
						report_mismatch("sin_theta_over_lambda", sin_theta_over_lambda,
							want.sthol);
					if (resolution !== want.dres)
						report_mismatch("resolution", resolution, want.dres);
				end
			end
			if (out_stall > 0) begin
				out_stall <= out_stall - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				out_stall <= pick_gap();
			end
		end
	end

	// Watchdog on cycles in which neither channel moves an item.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_HH: m_hh = val[30:0];
			REG_KK: m_kk = val[30:0];
			REG_LL: m_ll = val[30:0];
			REG_HK: m_hk = val;
			REG_HL: m_hl = val;
			REG_KL: m_kl = val;
			default: ;
		endcase
	endtask

	task automatic set_metric(logic [31:0] hh, kk, ll, hk, hl, kl);
		write_reg(REG_HH, hh);
		write_reg(REG_KK, kk);
		write_reg(REG_LL, ll);
		write_reg(REG_HK, hk);
		write_reg(REG_HL, hl);
		write_reg(REG_KL, kl);
	endtask

	task automatic add_item(int h, int k, int l);
		refl_t r;
		r.h = IDX_W'(h);
		r.k = IDX_W'(k);
		r.l = IDX_W'(l);
		reflections.push_back(r);
	endtask

	task automatic add_random(int n);
		int lim;
		for (int i = 0; i < n; i++) begin
			if (i % 150 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			lim = ($urandom_range(0, 2) == 0) ? 255 : 12;
			if (lim == 255)
				add_item($urandom_range(0, 511) - 256, $urandom_range(0, 511) - 256,
					$urandom_range(0, 511) - 256);
			else
				add_item($urandom_range(0, 24) - 12, $urandom_range(0, 24) - 12,
					$urandom_range(0, 24) - 12);
		end
	endtask

	// The last item must have left the driver and come back before anything else.
	task automatic drain();
		wait (reflections.size() == 0 && !in_valid && expected_res.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		errors = 0;
		no_idle = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_HH;
		cfg_wdata = '0;
		m_hh = '0; m_kk = '0; m_ll = '0;
		m_hk = '0; m_hl = '0; m_kl = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Reset coefficients: every nonzero reflection has a zero form.
		add_item(0, 0, 0);
		add_item(1, 0, 0);
		add_item(-256, 255, -1);
		add_random(40);
		drain();

		// Tiny metric: resolution saturates; an opposing cross term drives the form negative.
		set_metric(32'd1, 32'd1, 32'd1, 32'h8000_0000, 32'd0, 32'd0);
		add_item(1, 0, 0);
		add_item(0, 0, 1);
		add_item(1, 1, 0);
		add_item(1, -1, 0);
		add_item(0, 0, 0);
		add_item(255, 255, 0);
		add_random(150);
		drain();

		// Largest coefficients everywhere, then the most negative cross terms.
		set_metric(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		write_reg(REG_SPARE_A, 32'h1234_5678);
		write_reg(REG_SPARE_B, 32'hFFFF_FFFF);
		add_item(-256, -256, -256);
		add_item(255, 255, 255);
		add_item(-256, 255, -256);
		add_item(255, 0, 0);
		add_item(0, -256, 0);
		add_item(0, 0, 255);
		add_random(250);
		drain();
		set_metric(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		add_item(-256, -256, -256);
		add_item(255, -256, 255);
		add_item(1, 1, 1);
		add_random(250);
		drain();

		// Realistic cells and fully random coefficients.
		for (int p = 0; p < 4; p++) begin
			if (p < 2)
				set_metric($urandom_range(1_000_000, 200_000_000),
					$urandom_range(1_000_000, 200_000_000),
					$urandom_range(1_000_000, 200_000_000),
					$urandom_range(0, 40_000_000) - 20_000_000,
					$urandom_range(0, 40_000_000) - 20_000_000,
					$urandom_range(0, 40_000_000) - 20_000_000);
			else
				set_metric($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			add_random(200);
			drain();
		end

		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== reflection_resolution_calc.f =====
rtl/rrc_pkg.sv
rtl/rrc_root_stage.sv
rtl/reflection_resolution_calc.sv
rtl/rrc_checker.sv
verif/testbench.sv
